[src/cgb_pkg.sv]
// shared types and codes for the csr graph builder
`timescale 1ns / 1ps

package cgb_pkg;

    // field widths fixed by the word format
    localparam int VID_W    = 10;
    localparam int EDGE_W   = 2 * VID_W;
    localparam int CMD_W    = 2;
    localparam int RIDX_W   = 13;
    localparam int VALUE_W  = 14;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 13;
    localparam int CFG_W    = 11;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_NBR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_VERTEX  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STORE_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WRONG_PHASE = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_ZERO,
        S_CNT_EDGE,
        S_CNT_A_WR,
        S_CNT_B_RD,
        S_CNT_B_WR,
        S_PREFIX,
        S_PF_DRAIN,
        S_SC_EDGE,
        S_SC_A_WR,
        S_SC_B_RD,
        S_SC_B_WR
    } t_state;

endpackage

[src/cgb_ram.sv]
// simple dual-port ram with one write port and a registered read port
`timescale 1ns / 1ps

module cgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/csr_graph_builder.sv]
// top level of the csr graph builder: command decode, build sequencer and its memories
`timescale 1ns / 1ps
// Builds a compressed sparse row graph from undirected edges held in on-chip
// memories. A command word is taken when start is high and busy is low; every
// word gives exactly one result, shown for one cycle with o_result_strobe, and
// the receiver cannot stall it. Adds, clears and rejected words give their
// result in the cycle after they are taken; an accepted offset or neighbor
// read first passes through a busy read state for the registered memory read.
// An accepted add marked last starts the build and keeps busy high through a
// zeroing sweep and a prefix sweep over the offset memory of MAX_VERTICES+1
// entries each, plus one read-modify-write pass over the edge store for degree
// counting and another for the neighbor scatter, an edge being skipped when an
// endpoint is out of range. The vertex count register is written through
// i_cfg_we / i_cfg_wdata and must only change while the block is idle.

module csr_graph_builder #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cgb_pkg::CMD_W-1:0]     i_command,
    input  logic [cgb_pkg::VID_W-1:0]     i_vertex_a,
    input  logic [cgb_pkg::VID_W-1:0]     i_vertex_b,
    input  logic                          i_last_edge,
    input  logic [cgb_pkg::RIDX_W-1:0]    i_read_index,
    input  logic                          i_cfg_we,
    input  logic [cgb_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_result_strobe,
    output logic [cgb_pkg::VALUE_W-1:0]   o_read_value,
    output logic [cgb_pkg::STATUS_W-1:0]  o_status,
    output logic [cgb_pkg::COUNT_W-1:0]   o_edge_count
);

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int OIW    = $clog2(MAX_VERTICES + 1);
    localparam int EW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW    = $clog2(MAX_EDGES + 1);
    localparam int NDEPTH = 2 * MAX_EDGES;
    localparam int NW     = $clog2(NDEPTH);
    localparam int OW     = $clog2(NDEPTH + 1);
    localparam logic [cgb_pkg::CFG_W-1:0] CFG_RESET =
        cgb_pkg::CFG_W'((MAX_VERTICES > 2047) ? 2047 : MAX_VERTICES);

    cgb_pkg::t_state r_state, n_state;

    logic [cgb_pkg::CFG_W-1:0]    r_cfg_nv;
    logic [ECW-1:0]               r_stored, n_stored;
    logic                         r_built, n_built;
    logic [OW-1:0]                r_total, n_total;
    logic [ECW-1:0]               r_edge_idx, n_edge_idx;
    logic [OIW-1:0]               r_sweep, n_sweep;
    logic [OW-1:0]                r_acc, n_acc;
    logic                         r_pf_valid, n_pf_valid;
    logic [OIW-1:0]               r_pf_addr, n_pf_addr;
    logic                         r_rd_nbr, n_rd_nbr;
    logic                         r_strobe, n_strobe;
    logic [cgb_pkg::VALUE_W-1:0]  r_value, n_value;
    logic [cgb_pkg::STATUS_W-1:0] r_status, n_status;

    // memory ports
    logic                         w_edge_we;
    logic [EW-1:0]                w_edge_waddr, w_edge_raddr;
    logic [cgb_pkg::EDGE_W-1:0]   w_edge_wdata, w_edge_rdata;
    logic                         w_off_we;
    logic [OIW-1:0]               w_off_waddr, w_off_raddr;
    logic [OW-1:0]                w_off_wdata, w_off_rdata;
    logic                         w_pos_we;
    logic [VW-1:0]                w_pos_waddr, w_pos_raddr;
    logic [OW-1:0]                w_pos_wdata, w_pos_rdata;
    logic                         w_nbr_we;
    logic [NW-1:0]                w_nbr_waddr, w_nbr_raddr;
    logic [cgb_pkg::VID_W-1:0]    w_nbr_wdata, w_nbr_rdata;

    // decoded conditions
    logic [OIW-1:0]               w_n;
    logic                         w_accept;
    logic                         w_add_bad, w_full, w_add_ok;
    logic                         w_off_bad, w_nbr_bad;
    logic [cgb_pkg::VID_W-1:0]    w_edge_a, w_edge_b;
    logic                         w_edge_ok;
    logic [ECW-1:0]               w_idx_inc;
    logic                         w_idx_last;
    logic [OIW-1:0]               w_a_inc, w_b_inc;
    logic [OW-1:0]                w_off_inc, w_pos_inc, w_pf_sum;
    logic                         w_sweep_last;

    // vertices in use, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_cfg_nv == '0) begin
            w_n = OIW'(1);
        end else if (32'(r_cfg_nv) > 32'(MAX_VERTICES)) begin
            w_n = OIW'(MAX_VERTICES);
        end else begin
            w_n = OIW'(r_cfg_nv);
        end
    end

    // command word checks
    assign w_accept  = start && !busy;
    assign w_add_bad = (32'(i_vertex_a) >= 32'(w_n)) || (32'(i_vertex_b) >= 32'(w_n));
    assign w_full    = (r_stored == ECW'(MAX_EDGES));
    assign w_add_ok  = !r_built && !w_add_bad && !w_full;
    assign w_off_bad = 32'(i_read_index) > 32'(w_n);
    assign w_nbr_bad = (32'(i_read_index) >= 32'(r_total)) ||
                       (32'(i_read_index) >= 32'(NDEPTH));

    // stored edge under work during the build passes
    assign w_edge_a     = w_edge_rdata[cgb_pkg::VID_W-1:0];
    assign w_edge_b     = w_edge_rdata[cgb_pkg::EDGE_W-1:cgb_pkg::VID_W];
    assign w_edge_ok    = (32'(w_edge_a) < 32'(w_n)) && (32'(w_edge_b) < 32'(w_n));
    assign w_idx_inc    = r_edge_idx + ECW'(1);
    assign w_idx_last   = (w_idx_inc == r_stored);
    assign w_a_inc      = OIW'(w_edge_a) + OIW'(1);
    assign w_b_inc      = OIW'(w_edge_b) + OIW'(1);
    assign w_off_inc    = w_off_rdata + OW'(1);
    assign w_pos_inc    = w_pos_rdata + OW'(1);
    assign w_pf_sum     = r_acc + w_off_rdata;
    assign w_sweep_last = (r_sweep == OIW'(MAX_VERTICES));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cgb_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        cgb_pkg::CMD_ADD: begin
                            if (w_add_ok && i_last_edge) n_state = cgb_pkg::S_ZERO;
                        end
                        cgb_pkg::CMD_READ_OFF: begin
                            if (r_built && !w_off_bad) n_state = cgb_pkg::S_READ;
                        end
                        cgb_pkg::CMD_READ_NBR: begin
                            if (r_built && !w_nbr_bad) n_state = cgb_pkg::S_READ;
                        end
                        default: n_state = cgb_pkg::S_IDLE;
                    endcase
                end
            end
            cgb_pkg::S_READ:     n_state = cgb_pkg::S_IDLE;
            cgb_pkg::S_ZERO: begin
                if (w_sweep_last) n_state = cgb_pkg::S_CNT_EDGE;
            end
            cgb_pkg::S_CNT_EDGE: begin
                if (w_edge_ok)       n_state = cgb_pkg::S_CNT_A_WR;
                else if (w_idx_last) n_state = cgb_pkg::S_PREFIX;
            end
            cgb_pkg::S_CNT_A_WR: n_state = cgb_pkg::S_CNT_B_RD;
            cgb_pkg::S_CNT_B_RD: n_state = cgb_pkg::S_CNT_B_WR;
            cgb_pkg::S_CNT_B_WR: begin
                n_state = w_idx_last ? cgb_pkg::S_PREFIX : cgb_pkg::S_CNT_EDGE;
            end
            cgb_pkg::S_PREFIX: begin
                if (w_sweep_last) n_state = cgb_pkg::S_PF_DRAIN;
            end
            cgb_pkg::S_PF_DRAIN: n_state = cgb_pkg::S_SC_EDGE;
            cgb_pkg::S_SC_EDGE: begin
                if (w_edge_ok)       n_state = cgb_pkg::S_SC_A_WR;
                else if (w_idx_last) n_state = cgb_pkg::S_IDLE;
            end
            cgb_pkg::S_SC_A_WR:  n_state = cgb_pkg::S_SC_B_RD;
            cgb_pkg::S_SC_B_RD:  n_state = cgb_pkg::S_SC_B_WR;
            cgb_pkg::S_SC_B_WR: begin
                n_state = w_idx_last ? cgb_pkg::S_IDLE : cgb_pkg::S_SC_EDGE;
            end
            default: n_state = cgb_pkg::S_IDLE;
        endcase
    end

    // handshake output
    always_comb begin
        busy = (r_state != cgb_pkg::S_IDLE);
    end

    // datapath and memory control
    always_comb begin
        n_stored   = r_stored;
        n_built    = r_built;
        n_total    = r_total;
        n_edge_idx = r_edge_idx;
        n_sweep    = r_sweep;
        n_acc      = r_acc;
        n_pf_valid = (r_state == cgb_pkg::S_PREFIX);
        n_pf_addr  = r_sweep;
        n_rd_nbr   = r_rd_nbr;
        n_strobe   = 1'b0;
        n_value    = r_value;
        n_status   = r_status;

        w_edge_we    = 1'b0;
        w_edge_waddr = r_stored[EW-1:0];
        w_edge_wdata = {i_vertex_b, i_vertex_a};
        w_off_we     = 1'b0;
        w_off_waddr  = r_sweep;
        w_off_wdata  = '0;
        w_off_raddr  = r_sweep;
        w_pos_we     = 1'b0;
        w_pos_waddr  = VW'(w_edge_a);
        w_pos_wdata  = w_pos_inc;
        w_pos_raddr  = VW'(w_edge_a);
        w_nbr_we     = 1'b0;
        w_nbr_waddr  = NW'(w_pos_rdata);
        w_nbr_wdata  = w_edge_b;
        w_nbr_raddr  = NW'(i_read_index);

        // prefix write stage, one entry behind the prefix read sweep
        if (r_pf_valid) begin
            w_off_we    = 1'b1;
            w_off_waddr = r_pf_addr;
            w_off_wdata = w_pf_sum;
            n_acc       = w_pf_sum;
            if (32'(r_pf_addr) < 32'(MAX_VERTICES)) begin
                w_pos_we    = 1'b1;
                w_pos_waddr = VW'(r_pf_addr);
                w_pos_wdata = w_pf_sum;
            end
        end

        case (r_state)
            cgb_pkg::S_IDLE: begin
                w_off_raddr = OIW'(i_read_index);
                if (w_accept) begin
                    n_strobe = 1'b1;
                    n_value  = '0;
                    n_status = cgb_pkg::ST_OK;
                    n_sweep  = '0;
                    unique case (i_command)
                        cgb_pkg::CMD_ADD: begin
                            if (r_built) begin
                                n_status = cgb_pkg::ST_WRONG_PHASE;
                            end else if (w_add_bad) begin
                                n_status = cgb_pkg::ST_BAD_VERTEX;
                            end else if (w_full) begin
                                n_status = cgb_pkg::ST_STORE_FULL;
                            end else begin
                                w_edge_we = 1'b1;
                                n_stored  = r_stored + ECW'(1);
                            end
                        end
                        cgb_pkg::CMD_READ_OFF: begin
                            n_rd_nbr = 1'b0;
                            if (!r_built) begin
                                n_status = cgb_pkg::ST_WRONG_PHASE;
                            end else if (w_off_bad) begin
                                n_status = cgb_pkg::ST_BAD_INDEX;
                            end else begin
                                n_strobe = 1'b0;
                            end
                        end
                        cgb_pkg::CMD_READ_NBR: begin
                            n_rd_nbr = 1'b1;
                            if (!r_built) begin
                                n_status = cgb_pkg::ST_WRONG_PHASE;
                            end else if (w_nbr_bad) begin
                                n_status = cgb_pkg::ST_BAD_INDEX;
                            end else begin
                                n_strobe = 1'b0;
                            end
                        end
                        default: begin
                            n_stored = '0;
                            n_built  = 1'b0;
                            n_total  = '0;
                        end
                    endcase
                end
            end
            cgb_pkg::S_READ: begin
                n_strobe = 1'b1;
                n_status = cgb_pkg::ST_OK;
                n_value  = r_rd_nbr ? cgb_pkg::VALUE_W'(w_nbr_rdata)
                                    : cgb_pkg::VALUE_W'(w_off_rdata);
            end
            cgb_pkg::S_ZERO: begin
                w_off_we    = 1'b1;
                w_off_waddr = r_sweep;
                w_off_wdata = '0;
                if (w_sweep_last) begin
                    n_sweep    = '0;
                    n_edge_idx = '0;
                    n_acc      = '0;
                end else begin
                    n_sweep = r_sweep + OIW'(1);
                end
            end
            cgb_pkg::S_CNT_EDGE: begin
                w_off_raddr = w_a_inc;
                if (!w_edge_ok) n_edge_idx = w_idx_inc;
            end
            cgb_pkg::S_CNT_A_WR: begin
                w_off_we    = 1'b1;
                w_off_waddr = w_a_inc;
                w_off_wdata = w_off_inc;
            end
            cgb_pkg::S_CNT_B_RD: begin
                w_off_raddr = w_b_inc;
            end
            cgb_pkg::S_CNT_B_WR: begin
                w_off_we    = 1'b1;
                w_off_waddr = w_b_inc;
                w_off_wdata = w_off_inc;
                n_edge_idx  = w_idx_inc;
            end
            cgb_pkg::S_PREFIX: begin
                w_off_raddr = r_sweep;
                if (!w_sweep_last) n_sweep = r_sweep + OIW'(1);
            end
            cgb_pkg::S_PF_DRAIN: begin
                n_total    = w_pf_sum;
                n_edge_idx = '0;
            end
            cgb_pkg::S_SC_EDGE: begin
                w_pos_raddr = VW'(w_edge_a);
                if (!w_edge_ok) begin
                    n_edge_idx = w_idx_inc;
                    if (w_idx_last) n_built = 1'b1;
                end
            end
            cgb_pkg::S_SC_A_WR: begin
                w_pos_we    = 1'b1;
                w_pos_waddr = VW'(w_edge_a);
                w_pos_wdata = w_pos_inc;
                w_nbr_we    = (32'(w_pos_rdata) < 32'(NDEPTH));
                w_nbr_waddr = NW'(w_pos_rdata);
                w_nbr_wdata = w_edge_b;
            end
            cgb_pkg::S_SC_B_RD: begin
                w_pos_raddr = VW'(w_edge_b);
            end
            cgb_pkg::S_SC_B_WR: begin
                w_pos_we    = 1'b1;
                w_pos_waddr = VW'(w_edge_b);
                w_pos_wdata = w_pos_inc;
                w_nbr_we    = (32'(w_pos_rdata) < 32'(NDEPTH));
                w_nbr_waddr = NW'(w_pos_rdata);
                w_nbr_wdata = w_edge_a;
                n_edge_idx  = w_idx_inc;
                if (w_idx_last) n_built = 1'b1;
            end
            default: ;
        endcase
    end

    // edge store read follows the next edge index, so its data matches r_edge_idx
    assign w_edge_raddr = n_edge_idx[EW-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cgb_pkg::S_IDLE;
            r_cfg_nv   <= CFG_RESET;
            r_stored   <= '0;
            r_built    <= 1'b0;
            r_total    <= '0;
            r_pf_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_stored   <= n_stored;
            r_built    <= n_built;
            r_total    <= n_total;
            r_pf_valid <= n_pf_valid;
            r_strobe   <= n_strobe;
            if (i_cfg_we) r_cfg_nv <= i_cfg_wdata;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_edge_idx <= n_edge_idx;
        r_sweep    <= n_sweep;
        r_acc      <= n_acc;
        r_pf_addr  <= n_pf_addr;
        r_rd_nbr   <= n_rd_nbr;
        r_value    <= n_value;
        r_status   <= n_status;
    end

    // result word
    assign o_result_strobe = r_strobe;
    assign o_read_value    = r_value;
    assign o_status        = r_status;
    assign o_edge_count    = cgb_pkg::COUNT_W'(r_stored);

    // edge store, packed endpoint pairs
    cgb_ram #(.WIDTH(cgb_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (w_edge_waddr),
        .i_wdata (w_edge_wdata),
        .i_raddr (w_edge_raddr),
        .o_rdata (w_edge_rdata)
    );

    // degree counts, then offsets after the prefix sweep
    cgb_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES + 1)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (w_off_we),
        .i_waddr (w_off_waddr),
        .i_wdata (w_off_wdata),
        .i_raddr (w_off_raddr),
        .o_rdata (w_off_rdata)
    );

    // per-vertex scatter positions
    cgb_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (w_pos_waddr),
        .i_wdata (w_pos_wdata),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    // neighbor array
    cgb_ram #(.WIDTH(cgb_pkg::VID_W), .DEPTH(NDEPTH)) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (w_nbr_we),
        .i_waddr (w_nbr_waddr),
        .i_wdata (w_nbr_wdata),
        .i_raddr (w_nbr_raddr),
        .o_rdata (w_nbr_rdata)
    );

endmodule

[src/cgb_checker.sv]
// port-level assertions for the csr graph builder, bound to the top level
`timescale 1ns / 1ps

module cgb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [cgb_pkg::CMD_W-1:0]     i_command,
    input logic                          i_last_edge,
    input logic                          o_result_strobe,
    input logic [cgb_pkg::VALUE_W-1:0]   o_read_value,
    input logic [cgb_pkg::STATUS_W-1:0]  o_status,
    input logic [cgb_pkg::COUNT_W-1:0]   o_edge_count
);

    logic w_accept;
    assign w_accept = start && !busy;

    // every result word follows an accepted command word
    a_result_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> ($past(w_accept) || $past(w_accept, 2)))
        else $error("result word without an accepted command word");

    // a failed word carries a zero value
    a_fail_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_status != cgb_pkg::ST_OK)) |-> (o_read_value == '0))
        else $error("non-zero read value on a failed word");

    // a good last edge starts the build, so the block is busy at its result
    a_last_edge_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_status == cgb_pkg::ST_OK) &&
         $past(w_accept && (i_command == cgb_pkg::CMD_ADD) && i_last_edge)) |-> busy)
        else $error("last edge accepted without starting the build");

    // clear empties the graph
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept && (i_command == cgb_pkg::CMD_CLEAR)) |->
        (o_result_strobe && (o_status == cgb_pkg::ST_OK) && (o_edge_count == '0)))
        else $error("clear did not give an empty ok result");

    // adds give their result in the next cycle
    a_add_next_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == cgb_pkg::CMD_ADD)) |=> o_result_strobe)
        else $error("add word without a result in the next cycle");

endmodule

bind csr_graph_builder cgb_checker u_cgb_checker (.*);
